FILE: rtl/hvte_pkg.sv
// ----------------------------------------------------------------------------
// HTML visible text extractor package
// Shared types, character codes and the tag name table.
// ----------------------------------------------------------------------------
package hvte_pkg;

  // Number of tag names that switch skip mode, and the longest of them.
  localparam int NumNames = 7;
  localparam int MaxName  = 8;

  // Default depth of the command queue between front and back end.
  localparam int QueueDepthDef = 2;

  // Character codes.
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Tag names, zero padded to the longest name.
  localparam logic [7:0] KW_TEXT [NumNames][MaxName] = '{
    '{"s", "c", "r", "i", "p", "t", 8'h00, 8'h00},
    '{"s", "t", "y", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"h", "e", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"n", "o", "s", "c", "r", "i", "p", "t"},
    '{"m", "e", "t", "a", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "i", "n", "k", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "i", "t", "l", "e", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [NumNames] = '{
    4'd6, 4'd5, 4'd4, 4'd8, 4'd4, 4'd4, 4'd5
  };

  // Kind of work that the front end hands to the back end.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CHAR,
    CMD_SPACE
  } cmd_kind_e;

  // One queue entry: a text byte, a conditional space, or nothing, plus
  // the end-of-document flag.
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // Front end status, watched by the top level checks.
  typedef struct packed {
    logic in_tag;
    logic skip;
  } fe_stat_t;

  // C-locale whitespace: space, TAB, LF, VT, FF and CR.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

FILE: rtl/hvte_front.sv
// ----------------------------------------------------------------------------
// HTML visible text extractor front end
// Accepts one byte per transfer, tracks the tag parser and the tag name
// match, and turns each byte into a command for the back end.
// ----------------------------------------------------------------------------
module hvte_front
  import hvte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o,
  output fe_stat_t   stat_o
);

  // Parser modes.
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_OPEN = 2'd1;
  localparam logic [1:0] MODE_NAME = 2'd2;
  localparam logic [1:0] MODE_REST = 2'd3;

  logic [1:0]          mode_q, mode_d;
  logic                closing_q, closing_d;
  logic                skip_q, skip_d;
  logic [NumNames-1:0] cand_q, cand_d;
  logic [3:0]          len_q, len_d;

  logic       accept;
  logic       name_byte;
  logic       tag_end;
  logic       hit;
  logic [7:0] lc;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Lower-case the byte for name matching.
  assign lc = ((in_byte_i >= CH_UC_A) && (in_byte_i <= CH_UC_Z)) ?
              in_byte_i + CASE_OFS : in_byte_i;

  // A finished name hits when a surviving candidate has exactly its length.
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NumNames; k++) begin
      if (cand_q[k] && (KW_LEN[k] == len_q)) begin
        hit = 1'b1;
      end
    end
  end

  // Byte classification and next parser state.
  always_comb begin
    mode_d    = mode_q;
    closing_d = closing_q;
    skip_d    = skip_q;
    cand_d    = cand_q;
    len_d     = len_q;
    name_byte = 1'b0;
    tag_end   = 1'b0;
    cmd_o     = '{kind: CMD_NONE, data: in_byte_i, last: last_byte_i};

    case (mode_q)
      MODE_TEXT: begin
        if (in_byte_i == CH_LT) begin
          mode_d    = MODE_OPEN;
          closing_d = 1'b0;
          cand_d    = '1;
          len_d     = '0;
        end else if (!skip_q) begin
          cmd_o.kind = is_ws(in_byte_i) ? CMD_SPACE : CMD_CHAR;
        end
      end
      MODE_OPEN, MODE_NAME: begin
        if ((mode_q == MODE_OPEN) && (in_byte_i == CH_SLASH)) begin
          closing_d = 1'b1;
          mode_d    = MODE_NAME;
        end else if (in_byte_i == CH_GT) begin
          tag_end = 1'b1;
        end else if (is_ws(in_byte_i)) begin
          mode_d = MODE_REST;
        end else begin
          mode_d    = MODE_NAME;
          name_byte = 1'b1;
        end
      end
      MODE_REST: begin
        if (in_byte_i == CH_GT) begin
          tag_end = 1'b1;
        end
      end
      default: begin
        mode_d = MODE_TEXT;
      end
    endcase

    // Narrow the candidate set by one name byte.
    if (name_byte) begin
      for (int k = 0; k < NumNames; k++) begin
        if ((len_q >= KW_LEN[k]) || (len_q >= 4'(MaxName)) ||
            (KW_TEXT[k][len_q[2:0]] != lc)) begin
          cand_d[k] = 1'b0;
        end
      end
      if (len_q != 4'hF) begin
        len_d = len_q + 4'd1;
      end
    end

    // A '>' ends the tag: a matching name switches skip mode.
    if (tag_end) begin
      if (hit) begin
        skip_d = !closing_q;
      end
      mode_d     = MODE_TEXT;
      cmd_o.kind = CMD_SPACE;
    end

    // The final byte closes an unfinished tag and resets the parser.
    if (last_byte_i) begin
      if (mode_d != MODE_TEXT) begin
        cmd_o.kind = CMD_SPACE;
      end
      mode_d    = MODE_TEXT;
      closing_d = 1'b0;
      skip_d    = 1'b0;
      cand_d    = '1;
      len_d     = '0;
    end
  end

  assign push_o = accept && ((cmd_o.kind != CMD_NONE) || last_byte_i);

  // Parser state advances on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_TEXT;
      closing_q <= 1'b0;
      skip_q    <= 1'b0;
      cand_q    <= '1;
      len_q     <= '0;
    end else if (accept) begin
      mode_q    <= mode_d;
      closing_q <= closing_d;
      skip_q    <= skip_d;
      cand_q    <= cand_d;
      len_q     <= len_d;
    end
  end

  assign stat_o = '{in_tag: (mode_q != MODE_TEXT), skip: skip_q};

endmodule

FILE: rtl/hvte_queue.sv
// ----------------------------------------------------------------------------
// HTML visible text extractor command queue
// Short first-in first-out queue that decouples front and back end.
// ----------------------------------------------------------------------------
module hvte_queue
  import hvte_pkg::*;
#(
  parameter int Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/hvte_back.sv
// ----------------------------------------------------------------------------
// HTML visible text extractor back end
// Applies the space collapsing rule to queued commands and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module hvte_back
  import hvte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       end_of_text_o
);

  logic       out_vld_q, out_vld_d;
  logic [7:0] byte_q;
  logic       has_q;
  logic       eot_q;
  logic       started_q, started_d;
  logic       space_q, space_d;

  logic       slot_free;
  logic       emit;
  logic [7:0] emit_byte;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_vld_q || !out_stall_i;
  assign pop_o     = !empty_i && slot_free;

  // A space is emitted only after text and not after another space.
  assign emit = (head_i.kind == CMD_CHAR) ||
                ((head_i.kind == CMD_SPACE) && started_q && !space_q);
  assign emit_byte = (head_i.kind == CMD_CHAR) ? head_i.data : CH_SPACE;

  always_comb begin
    out_vld_d = out_vld_q;
    started_d = started_q;
    space_d   = space_q;
    if (pop_o) begin
      out_vld_d = emit || head_i.last;
      if (emit) begin
        started_d = 1'b1;
        space_d   = (emit_byte == CH_SPACE);
      end
      if (head_i.last) begin
        started_d = 1'b0;
        space_d   = 1'b0;
      end
    end else if (slot_free) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      started_q <= 1'b0;
      space_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      started_q <= started_d;
      space_q   <= space_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q <= emit ? emit_byte : 8'h00;
      has_q  <= emit;
      eot_q  <= head_i.last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign out_byte_o    = byte_q;
  assign has_byte_o    = has_q;
  assign end_of_text_o = eot_q;

endmodule

FILE: rtl/html_visible_text_extractor_top.sv
// ----------------------------------------------------------------------------
// HTML visible text extractor
// Strips tags and skipped sections from an HTML byte stream and collapses
// whitespace runs, giving the visible text one byte per transfer.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid_i / in_stall_o  in_byte_i, last_byte_i
//   output   out        out_valid_o / out_stall_i out_byte_o, has_byte_o,
//                                                end_of_text_o
//
// One input byte is taken every cycle unless in_stall_o is high; the taking
// edge writes its command to the queue, and the output register loads it once
// free. The front end parser decides one byte per cycle and the back end drains
// one queue entry per cycle, each while not stalled. Reset is asynchronous and
// clears the parser, queue and output register. A stalled output fills the
// command queue; once it is full, in_stall_o rises. A document's final byte
// returns the parser and space collapsing state to reset.
// ----------------------------------------------------------------------------
module html_visible_text_extractor_top
  import hvte_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       end_of_text_o
);

  logic     push;
  cmd_t     push_cmd;
  cmd_t     head_cmd;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  fe_stat_t fe_stat;

  hvte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .stat_o      (fe_stat)
  );

  hvte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  hvte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .has_byte_o    (has_byte_o),
    .end_of_text_o (end_of_text_o)
  );

  // A result without a text byte only exists as an end marker.
  a_empty_result_is_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> end_of_text_o)
    else $error("result carries neither a byte nor an end marker");

  // The queue cannot be full and empty at once.
  a_queue_count_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  // The final byte leaves the parser in text mode with skip mode off.
  a_last_resets_parser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_byte_i |=> !fe_stat.in_tag && !fe_stat.skip)
    else $error("parser not reset after the final byte");

endmodule

FILE: bench/html_visible_text_extractor_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTML visible text extractor testbench
// Feeds short HTML documents, a handful written by hand and many built at
// random from text, whitespace runs, tags and noise, through the extractor
// with random idle cycles on the input and random stalls on the output.
// A behavioral parser inside the bench predicts each result, and a monitor
// compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module html_visible_text_extractor_top_tb;

  // Character codes that steer the parser.
  localparam logic [7:0] LT_CHAR    = 8'h3C;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] GT_CHAR    = 8'h3E;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  localparam int NUM_TAGS     = 7;
  localparam int RANDOM_BYTES = 1900;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 1000000;

  // Parser position within the byte stream.
  typedef enum logic [1:0] {
    PM_TEXT,
    PM_OPEN,
    PM_NAME,
    PM_REST
  } parse_mode_e;

  // One input byte of a document.
  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } html_byte_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] text;
    logic       has_text;
    logic       eot;
  } text_result_t;

  // Tag names that switch skip mode.
  string tag_names [NUM_TAGS] = '{"script", "style", "head", "noscript", "meta", "link",
                                  "title"};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       has_byte_o;
  logic       end_of_text_o;

  html_byte_t   pending_bytes [$];
  text_result_t expected_text [$];

  // Parser state of the prediction.
  parse_mode_e mode       = PM_TEXT;
  bit          closing    = 1'b0;
  bit          skipping   = 1'b0;
  bit          started    = 1'b0;
  bit          prev_space = 1'b0;
  logic [6:0]  cands      = '1;
  logic [3:0]  name_len   = '0;

  html_byte_t   cur_byte;
  text_result_t predicted;
  text_result_t seen;
  text_result_t want;
  int           idle_left     = 0;
  int           calm_in       = 0;
  int           stall_left    = 0;
  int           calm_out      = 0;
  int           bytes_taken   = 0;
  int           total_bytes   = -1;
  int           mismatch_count = 0;
  int unsigned  cycle_count   = 0;

  html_visible_text_extractor_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .has_byte_o   (has_byte_o),
    .end_of_text_o(end_of_text_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // C-locale whitespace: space, TAB, LF, VT, FF and CR.
  function automatic bit is_blank(input logic [7:0] c);
    return (c == SPACE_CHAR) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void clear_parser();
    mode       = PM_TEXT;
    closing    = 1'b0;
    skipping   = 1'b0;
    started    = 1'b0;
    prev_space = 1'b0;
    cands      = '1;
    name_len   = '0;
  endfunction

  // Narrows the set of tag names that still match the name seen so far.
  function automatic void take_name_char(input logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + CASE_GAP : c;
    for (int k = 0; k < NUM_TAGS; k++) begin
      if (name_len >= tag_names[k].len() || tag_names[k][name_len] != lc) begin
        cands[k] = 1'b0;
      end
    end
    if (name_len != 4'd15) begin
      name_len++;
    end
  endfunction

  // Closes a tag; returns 1 when a separating space is due.
  function automatic bit close_tag();
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_TAGS; k++) begin
      if (cands[k] && tag_names[k].len() == name_len) begin
        hit = 1'b1;
      end
    end
    if (hit) begin
      skipping = !closing;
    end
    mode = PM_TEXT;
    return started && !prev_space;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte gives a result.
  function automatic bit extract_visible_text(input logic [7:0] c, input logic fin,
                                              output text_result_t res);
    bit         emit;
    logic [7:0] ob;
    emit = 1'b0;
    ob   = 8'h00;
    case (mode)
      PM_TEXT: begin
        if (c == LT_CHAR) begin
          mode     = PM_OPEN;
          closing  = 1'b0;
          cands    = '1;
          name_len = '0;
        end else if (!skipping) begin
          if (!is_blank(c)) begin
            emit = 1'b1;
            ob   = c;
          end else if (started && !prev_space) begin
            emit = 1'b1;
            ob   = SPACE_CHAR;
          end
        end
      end
      PM_OPEN, PM_NAME: begin
        if (mode == PM_OPEN && c == SLASH_CHAR) begin
          closing = 1'b1;
          mode    = PM_NAME;
        end else if (c == GT_CHAR) begin
          if (close_tag()) begin
            emit = 1'b1;
            ob   = SPACE_CHAR;
          end
        end else if (is_blank(c)) begin
          mode = PM_REST;
        end else begin
          mode = PM_NAME;
          take_name_char(c);
        end
      end
      default: begin
        if (c == GT_CHAR && close_tag()) begin
          emit = 1'b1;
          ob   = SPACE_CHAR;
        end
      end
    endcase
    // The final byte also ends an unfinished tag.
    if (fin && mode != PM_TEXT && close_tag()) begin
      emit = 1'b1;
      ob   = SPACE_CHAR;
    end
    if (emit) begin
      started    = 1'b1;
      prev_space = (ob == SPACE_CHAR);
    end
    res.text     = ob;
    res.has_text = emit;
    res.eot      = fin;
    if (fin) begin
      clear_parser();
    end
    return emit || fin;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Idle length: mostly none or short, a few long.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? SPACE_CHAR : 8'(8'h09 + r);
  endfunction

  task automatic add_byte(input logic [7:0] c, input logic fin);
    html_byte_t item;
    item.code = c;
    item.fin  = fin;
    pending_bytes = {pending_bytes, item};
  endtask

  task automatic add_str(input string s);
    foreach (s[i]) add_byte(s[i], 1'b0);
  endtask

  // Pushes a name with a random mix of upper and lower case.
  task automatic add_name(input string s);
    foreach (s[i]) begin
      if (s[i] >= "a" && s[i] <= "z" && $urandom_range(0, 1) == 1) begin
        add_byte(8'(s[i] - CASE_GAP), 1'b0);
      end else begin
        add_byte(s[i], 1'b0);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Input driver: takes bytes from the pending queue, idles at random.
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        // A transfer completes here; predict its result.
        if (in_valid_i) begin
          if (extract_visible_text(cur_byte.code, cur_byte.fin, predicted)) begin
            expected_text = {expected_text, predicted};
          end
          bytes_taken++;
        end
        if (idle_left > 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          cur_byte = pending_bytes.pop_front();
          in_valid_i  <= 1'b1;
          in_byte_i   <= cur_byte.code;
          last_byte_i <= cur_byte.fin;
          if (calm_in > 0) begin
            calm_in--;
          end else begin
            idle_left = draw_gap();
            if ($urandom_range(0, 149) == 0) calm_in = 100;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output stall: random runs with free cycles between them.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (calm_out > 0) begin
        calm_out--;
      end else begin
        stall_left = draw_gap();
        if ($urandom_range(0, 199) == 0) calm_out = 120;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction.
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.text     = out_byte_o;
      seen.has_text = has_byte_o;
      seen.eot      = end_of_text_o;
      if (expected_text.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: out_byte=%h has_byte=%b end_of_text=%b",
                   seen.text, seen.has_text, seen.eot);
        end
      end else begin
        want = expected_text.pop_front();
        if (seen.text !== want.text || seen.has_text !== want.has_text ||
            seen.eot !== want.eot) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected out_byte=%h has_byte=%b end_of_text=%b, got %h %b %b",
                     want.text, want.has_text, want.eot, seen.text, seen.has_text,
                     seen.eot);
          end
        end
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Documents, reset and end of run.
  // ------------------------------------------------------------------------
  initial begin
    int         goal;
    int         pick;
    int         shape;
    logic [7:0] c;
    string      kw;

    // Leading blanks, a skipped title with '<' in its rest, top byte last.
    add_str(" \tA<Title <>y</TITLE>");
    add_byte(8'hFF, 1'b1);
    // Empty tag, text, then a document that ends inside a tag name.
    add_str("<>b<met");
    add_byte("a", 1'b1);

    goal = pending_bytes.size() + RANDOM_BYTES;
    while (pending_bytes.size() < goal) begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 10))
      begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          // A word of text, sometimes with upper half bytes.
          repeat ($urandom_range(1, 6)) begin
            c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255)) :
                                             8'($urandom_range(33, 126));
            if (c == LT_CHAR) c = "x";
            add_byte(c, 1'b0);
          end
        end else if (pick < 48) begin
          repeat ($urandom_range(1, 4)) add_byte(pick_blank(), 1'b0);
        end else if (pick < 85) begin
          // A tag: known name, a near miss, or an arbitrary name.
          add_byte(LT_CHAR, 1'b0);
          if ($urandom_range(0, 2) == 0) add_byte(SLASH_CHAR, 1'b0);
          kw    = tag_names[$urandom_range(0, NUM_TAGS - 1)];
          shape = $urandom_range(0, 9);
          if (shape < 6) begin
            add_name(kw);
          end else if (shape == 6) begin
            add_name(kw.substr(0, $urandom_range(0, kw.len() - 2)));
          end else if (shape == 7) begin
            add_name({kw, "s"});
          end else begin
            repeat ($urandom_range(0, 18)) begin
              c = 8'($urandom_range(33, 126));
              if (c == GT_CHAR) c = "q";
              add_byte(c, 1'b0);
            end
          end
          if ($urandom_range(0, 2) == 0) begin
            add_byte(pick_blank(), 1'b0);
            repeat ($urandom_range(0, 6)) begin
              c = 8'($urandom_range(0, 255));
              if (c == GT_CHAR) c = "=";
              add_byte(c, 1'b0);
            end
          end
          if ($urandom_range(0, 15) != 0) add_byte(GT_CHAR, 1'b0);
        end else begin
          repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      // Some documents stop inside a tag.
      if ($urandom_range(0, 3) == 0) begin
        add_byte(LT_CHAR, 1'b0);
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range("a", "z")), 1'b0);
      end
      add_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    total_bytes = pending_bytes.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every byte to be taken and every result to arrive.
    while (bytes_taken != total_bytes || expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
